>>> src/stptc_pkg.sv
// Shared types and constants for the two-point temperature conversion.
// No dependencies.
package stptc_pkg;

  localparam int ADC_BITS   = 12;
  localparam int CAL_W      = 16;
  localparam int DEN_W      = 16;
  localparam int PROD_W     = ADC_BITS + CAL_W;
  localparam int DIV_W      = (PROD_W > 28) ? PROD_W : 28;
  localparam int OFF_W      = 20;
  localparam int MAG_W      = OFF_W - 1;
  localparam int DECI_W     = 12;
  localparam int LATENCY    = 2 * DIV_W + 4;

  localparam logic [CAL_W-1:0]  BLANK_WORD  = 16'hFFFF;
  localparam logic [CAL_W-1:0]  FULL_SCALE  = CAL_W'((1 << ADC_BITS) - 1);
  localparam logic [DIV_W-1:0]  CORR_LIMIT  = DIV_W'(3 * ((1 << ADC_BITS) - 1));
  localparam logic [DIV_W-1:0]  DECI_SPAN   = DIV_W'(1000);
  localparam logic [DECI_W-1:0] DECI_AT_LOW = DECI_W'(300);
  localparam logic [DIV_W-1:0]  Q_MAX_POS   = DIV_W'(1200);
  localparam logic [DIV_W-1:0]  Q_MAX_NEG   = DIV_W'(800);

  typedef enum logic [1:0] {
    REG_CAL_LOW  = 2'd0,
    REG_CAL_HIGH = 2'd1,
    REG_VREF_CAL = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] sensor_raw;
    logic [15:0] ref_raw;
  } in_req_t;

  typedef struct packed {
    logic               reading_valid;
    logic signed [11:0] deci_celsius;
  } out_res_t;

  typedef struct packed {
    logic vld;
    logic ok;
    logic neg;
  } div_side_t;

  typedef struct packed {
    div_side_t        side;
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_word_t;

endpackage

>>> src/stptc_div_cell.sv
// One restoring-division cell: retires one quotient bit per request.
// Depends on stptc_pkg.
module stptc_div_cell import stptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_word_t din,
  output div_word_t dout
);

  div_word_t        word_r;
  div_word_t        word_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial    = {din.rem, din.num[DIV_W-1]};
    diff     = trial - {1'b0, din.den};
    ge       = trial >= {1'b0, din.den};
    word_nxt = din;
    word_nxt.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    word_nxt.num = {din.num[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.side.vld <= 1'b0;
    end else begin
      word_r.side.vld <= word_nxt.side.vld;
    end
    word_r.side.ok  <= word_nxt.side.ok;
    word_r.side.neg <= word_nxt.side.neg;
    word_r.rem      <= word_nxt.rem;
    word_r.num      <= word_nxt.num;
    word_r.den      <= word_nxt.den;
  end

  assign dout = word_r;

endmodule

>>> src/stptc_div_chain.sv
// Row of division cells, one per quotient bit; quotient leaves in num.
// Depends on stptc_pkg and stptc_div_cell.
module stptc_div_chain import stptc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_word_t din,
  output div_word_t dout
);

  div_word_t link [DIV_W+1];

  assign link[0] = din;

  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    stptc_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dout = link[DIV_W];

endmodule

>>> src/sensor_temperature_two_point_convert.sv
// Top level: two-point calibrated temperature conversion, fully pipelined.
// Depends on stptc_pkg and stptc_div_chain.
//
//  channel  ports                          handshake
//  input    start, busy, in_req            start & !busy
//  result   out_strobe, out_res            out_strobe, one cycle
//  config   cfg_we, cfg_index, cfg_wdata   cfg_we
//
// One request per cycle while busy is low.
// Latency is set by the two division cell rows, one quotient bit per cell.
// busy is high only during reset; synchronous active-low reset clears valids.
// Results cannot be stalled.
module sensor_temperature_two_point_convert import stptc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_strobe,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [CAL_W-1:0] cal_low_r, cal_high_r, vref_cal_r;
  logic             cal_ok;
  logic             in_acc;
  logic             ok0;
  logic signed [CAL_W:0] span;
  logic             span_neg;
  logic [DEN_W-1:0] span_mag;

  div_word_t        a_r, a_out;
  logic             b_vld_r, b_ok_r, b_neg_r;
  logic [MAG_W-1:0] b_mag_r;
  div_word_t        c_r, c_out;
  out_res_t         res_nxt;
  logic             strobe_r;
  out_res_t         res_r;

  logic signed [OFF_W-1:0] offset;
  logic             corr_ok;
  logic [MAG_W-1:0] off_mag;
  logic [DIV_W-1:0] mag_ext;
  logic [DIV_W-1:0] q;
  logic             q_ok;

  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_low_r  <= BLANK_WORD;
      cal_high_r <= BLANK_WORD;
      vref_cal_r <= BLANK_WORD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_LOW:  cal_low_r  <= cfg_wdata;
        REG_CAL_HIGH: cal_high_r <= cfg_wdata;
        REG_VREF_CAL: vref_cal_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cal_ok = (cal_low_r != BLANK_WORD) && (cal_high_r != BLANK_WORD) &&
                  (vref_cal_r != BLANK_WORD) && (vref_cal_r != '0) &&
                  (cal_low_r != cal_high_r);

  assign span     = $signed({1'b0, cal_high_r}) - $signed({1'b0, cal_low_r});
  assign span_neg = span[CAL_W];
  assign span_mag = span_neg ? DEN_W'(-span) : DEN_W'(span);

  // stage 0: checks and sensor * vref
  assign ok0 = cal_ok && (in_req.ref_raw != '0) &&
               (in_req.sensor_raw <= FULL_SCALE) && (in_req.ref_raw <= FULL_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.side.vld <= 1'b0;
    end else begin
      a_r.side.vld <= in_acc;
    end
    a_r.side.ok  <= ok0;
    a_r.side.neg <= 1'b0;
    a_r.rem      <= '0;
    a_r.num      <= DIV_W'(PROD_W'(in_req.sensor_raw[ADC_BITS-1:0]) *
                           PROD_W'(vref_cal_r));
    a_r.den      <= in_req.ref_raw;
  end

  stptc_div_chain u_div_corr (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (a_r),
    .dout (a_out)
  );

  // stage B: offset from low point, sign and magnitude
  assign corr_ok = a_out.num <= CORR_LIMIT;
  assign offset  = $signed({1'b0, a_out.num[OFF_W-2:0]}) -
                   $signed({{(OFF_W-CAL_W){1'b0}}, cal_low_r});
  assign off_mag = offset[OFF_W-1] ? MAG_W'(-offset) : MAG_W'(offset);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_out.side.vld;
    end
    b_ok_r  <= a_out.side.ok && corr_ok;
    b_neg_r <= offset[OFF_W-1] ^ span_neg;
    b_mag_r <= off_mag;
  end

  // stage C: scale by the span in tenths
  assign mag_ext = DIV_W'(b_mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.side.vld <= 1'b0;
    end else begin
      c_r.side.vld <= b_vld_r;
    end
    c_r.side.ok  <= b_ok_r;
    c_r.side.neg <= b_neg_r;
    c_r.rem      <= '0;
    c_r.num      <= mag_ext * DECI_SPAN;
    c_r.den      <= span_mag;
  end

  stptc_div_chain u_div_line (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (c_r),
    .dout (c_out)
  );

  // output stage: offset from 30 C and range check
  assign q    = c_out.num;
  assign q_ok = c_out.side.neg ? (q <= Q_MAX_NEG) : (q <= Q_MAX_POS);

  always_comb begin
    res_nxt = '0;
    if (c_out.side.ok && q_ok) begin
      res_nxt.reading_valid = 1'b1;
      res_nxt.deci_celsius  = c_out.side.neg ? DECI_AT_LOW - q[DECI_W-1:0]
                                             : DECI_AT_LOW + q[DECI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= c_out.side.vld;
    end
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_acc, LATENCY))
    else $error("result without matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_res.reading_valid) |-> (out_res.deci_celsius == '0))
    else $error("rejected reading not zero");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.reading_valid) |->
      (out_res.deci_celsius >= -12'sd500 && out_res.deci_celsius <= 12'sd1500))
    else $error("valid reading out of range");

endmodule

>>> tb/sensor_temperature_two_point_convert_tb.sv
// Testbench for sensor_temperature_two_point_convert: directed and random requests
// checked against an in-bench predictor of the two-point conversion.
// Depends on stptc_pkg and the block's RTL.
`timescale 1ns / 1ps

module sensor_temperature_two_point_convert_tb;
  import stptc_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = LATENCY + 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_req = '0;
  logic        out_strobe;
  out_res_t    out_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  logic [15:0] cal_low_q, cal_high_q, vref_cal_q;
  out_res_t    expected_readings[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;

  sensor_temperature_two_point_convert DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sensor_temperature_two_point_convert");
      $finish;
    end
  end

  function automatic out_res_t predict_reading(in_req_t req);
    out_res_t res;
    longint corrected, span, offset, deci;
    res = '0;
    if (cal_low_q == BLANK_WORD || cal_high_q == BLANK_WORD || vref_cal_q == BLANK_WORD ||
        vref_cal_q == 0 || cal_low_q == cal_high_q || req.ref_raw == 0 ||
        req.sensor_raw > ADC_MAX || req.ref_raw > ADC_MAX)
      return res;
    corrected = (longint'(req.sensor_raw) * longint'(vref_cal_q)) / longint'(req.ref_raw);
    if (corrected > 3 * ADC_MAX) return res;
    span = longint'(cal_high_q) - longint'(cal_low_q);
    offset = corrected - longint'(cal_low_q);
    deci = 300 + (1000 * offset) / span;
    if (deci < -500 || deci > 1500) return res;
    res.reading_valid = 1'b1;
    res.deci_celsius = deci[11:0];
    return res;
  endfunction

  always @(negedge clk) begin
    out_res_t exp_res;
    if (rst_n && out_strobe) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: valid %0b deci %0d",
               out_res.reading_valid, out_res.deci_celsius);
        fail_count++;
      end else begin
        exp_res = expected_readings.pop_front();
        if (out_res.reading_valid !== exp_res.reading_valid) begin
          $error("reading_valid: expected %0b actual %0b",
                 exp_res.reading_valid, out_res.reading_valid);
          fail_count++;
        end
        if (out_res.deci_celsius !== exp_res.deci_celsius) begin
          $error("deci_celsius: expected %0d actual %0d",
                 exp_res.deci_celsius, out_res.deci_celsius);
          fail_count++;
        end
      end
    end
  end

  // Leaves start high on return; caller lowers it when done.
  task automatic send_request(logic [15:0] sensor, logic [15:0] refc);
    in_req_t req;
    req.sensor_raw = sensor;
    req.ref_raw = refc;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= req;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    expected_readings.push_back(predict_reading(req));
    @(posedge clk);
  endtask

  task automatic drain_and_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAL_LOW:  cal_low_q = val;
      REG_CAL_HIGH: cal_high_q = val;
      REG_VREF_CAL: vref_cal_q = val;
      default: ;
    endcase
  endtask

  task automatic set_calibration(logic [15:0] lo, logic [15:0] hi, logic [15:0] vref);
    drain_and_idle();
    write_cfg(REG_CAL_LOW, lo);
    write_cfg(REG_CAL_HIGH, hi);
    write_cfg(REG_VREF_CAL, vref);
  endtask

  task automatic send_edge_inputs();
    send_request(16'd0, 16'd1);
    send_request(16'd4095, 16'd4095);
    send_request(16'd4096, 16'd100);
    send_request(16'hFFFF, 16'd100);
    send_request(16'd100, 16'd0);
    send_request(16'd100, 16'd4096);
    send_request(16'd4095, 16'd1);
  endtask

  task automatic test_blank_and_degenerate();
    send_edge_inputs();
    set_calibration(16'd1000, 16'd1000, 16'd1500);
    send_request(16'd1000, 16'd1500);
    set_calibration(16'd1000, 16'd1400, 16'd0);
    send_request(16'd1000, 16'd1500);
    drain_and_idle();
    write_cfg(REG_VREF_CAL, BLANK_WORD);
    send_request(16'd1000, 16'd1500);
    drain_and_idle();
  endtask

  task automatic test_directed_extremes();
    set_calibration(16'd1000, 16'd1400, 16'd1500);
    send_edge_inputs();
    send_request(16'd1000, 16'd1500);
    send_request(16'd1600, 16'd1500);
    send_request(16'd1560, 16'd1500);
    send_request(16'd1561, 16'd1500);
    send_request(16'd680, 16'd1500);
    send_request(16'd679, 16'd1500);
    drain_and_idle();
    write_cfg(REG_UNUSED, 16'd0);
    send_request(16'd1200, 16'd1500);
    set_calibration(16'd1400, 16'd1000, 16'd1500);
    send_request(16'd1200, 16'd1500);
    send_request(16'd900, 16'd1500);
    set_calibration(16'd0, 16'hFFFE, 16'hFFFE);
    send_request(16'd4095, 16'd4095);
    send_request(16'd1, 16'd4095);
    set_calibration(16'hFFFE, 16'd0, 16'd1);
    send_request(16'd4095, 16'd1);
    drain_and_idle();
  endtask

  task automatic test_random_sweep();
    int lo, sp, target, refc, sens;
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 56 : 0;
      lo = int'($urandom_range(200, 3000));
      sp = int'($urandom_range(20, 1500));
      set_calibration(lo[15:0], 16'(($urandom_range(1) != 0) ? lo + sp : lo - sp),
                      16'($urandom_range(1, 4095)));
      for (int k = 0; k < 160; k++) begin
        if ($urandom_range(99) < 85) begin
          sp = int'(cal_high_q) - int'(cal_low_q);
          target = int'(cal_low_q) + (sp * (int'($urandom_range(0, 2200)) - 900)) / 1000;
          if (target < 0) target = 0;
          refc = int'($urandom_range(1, ADC_MAX));
          sens = (target * refc) / int'(vref_cal_q);
          if (sens > ADC_MAX) sens = ADC_MAX;
          send_request(sens[15:0], refc[15:0]);
        end else begin
          send_request(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
        end
      end
    end
    sender_idle_pct = 0;
    drain_and_idle();
  endtask

  initial begin
    cal_low_q = BLANK_WORD;
    cal_high_q = BLANK_WORD;
    vref_cal_q = BLANK_WORD;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_blank_and_degenerate();
    test_directed_extremes();
    test_random_sweep();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("PASS sensor_temperature_two_point_convert");
    end else begin
      $display("FAIL sensor_temperature_two_point_convert");
    end
    $finish;
  end

endmodule

>>> sim.f
src/stptc_pkg.sv
src/stptc_div_cell.sv
src/stptc_div_chain.sv
src/sensor_temperature_two_point_convert.sv
tb/sensor_temperature_two_point_convert_tb.sv
